// ===== design/ltw_pkg.sv =====
// ----------------------------------------------------------------------------
// ltw_pkg: shared types and constants for the 4-connected tile line walker
// Transaction payloads, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package ltw_pkg;

  localparam int GRID_SIZE_DEF = 32;
  localparam int COORD_W       = 5;
  localparam int ERR_W         = 8;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] tile_x;
    logic [COORD_W-1:0] tile_y;
    logic               last_tile;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic next_is_last;
  } status_t;

endpackage

// ===== design/ltw_datapath.sv =====
// ----------------------------------------------------------------------------
// ltw_datapath: line walk registers and output tile register
// Holds position, deltas, directions and error term; outputs one tile per emit.
// ----------------------------------------------------------------------------
module ltw_datapath #(
  parameter int GRID_SIZE = ltw_pkg::GRID_SIZE_DEF
) (
  input  logic               clk,
  input  ltw_pkg::in_item_t  in_data,
  input  ltw_pkg::cmd_t      cmd,
  output ltw_pkg::status_t   status,
  output ltw_pkg::out_item_t out_data
);

  localparam int CW = ltw_pkg::COORD_W;
  localparam int EW = ltw_pkg::ERR_W;
  localparam logic [CW-1:0] MAX_COORD = CW'(GRID_SIZE - 1);

  logic [CW-1:0] cx, cy, ex, ey, dx, dy, py;
  logic          sx_neg, sy_neg, pend;
  logic signed [EW-1:0] err;

  logic [CW-1:0] x0, y0, x1, y1, ldx, ldy;
  logic          at_end, mx, my;
  logic signed [EW:0]   e2, sdx, sdy;
  logic signed [EW-1:0] err_next;
  logic [CW-1:0] cx_next, cy_next;

  always_comb begin
    x0 = (in_data.start_x > MAX_COORD) ? MAX_COORD : in_data.start_x;
    y0 = (in_data.start_y > MAX_COORD) ? MAX_COORD : in_data.start_y;
    x1 = (in_data.end_x > MAX_COORD) ? MAX_COORD : in_data.end_x;
    y1 = (in_data.end_y > MAX_COORD) ? MAX_COORD : in_data.end_y;
    ldx = (x0 > x1) ? (x0 - x1) : (x1 - x0);
    ldy = (y0 > y1) ? (y0 - y1) : (y1 - y0);
  end

  always_comb begin
    at_end = (cx == ex) && (cy == ey);
    e2  = {err, 1'b0};
    sdx = $signed({{(EW + 1 - CW){1'b0}}, dx});
    sdy = $signed({{(EW + 1 - CW){1'b0}}, dy});
    mx  = e2 > -sdy;
    my  = e2 < sdx;
    err_next = err - (mx ? EW'(sdy) : EW'(0)) + (my ? EW'(sdx) : EW'(0));
    cx_next = mx ? (sx_neg ? cx - CW'(1) : cx + CW'(1)) : cx;
    cy_next = my ? (sy_neg ? cy - CW'(1) : cy + CW'(1)) : cy;
    status.next_is_last = !pend && at_end;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx     <= x0;
      cy     <= y0;
      ex     <= x1;
      ey     <= y1;
      dx     <= ldx;
      dy     <= ldy;
      sx_neg <= !(x0 < x1);
      sy_neg <= !(y0 < y1);
      err    <= EW'($signed({1'b0, ldx})) - EW'($signed({1'b0, ldy}));
      pend   <= 1'b0;
    end else if (cmd.emit) begin
      if (pend) begin
        out_data.tile_x    <= cx;
        out_data.tile_y    <= py;
        out_data.last_tile <= 1'b0;
        pend               <= 1'b0;
      end else begin
        out_data.tile_x    <= cx;
        out_data.tile_y    <= cy;
        out_data.last_tile <= at_end;
        if (!at_end) begin
          cx   <= cx_next;
          cy   <= cy_next;
          err  <= err_next;
          py   <= cy;
          pend <= mx && my;
        end
      end
    end
  end

endmodule

// ===== design/ltw_ctrl.sv =====
// ----------------------------------------------------------------------------
// ltw_ctrl: handshake and sequencing controller
// Accepts a request in idle, issues one emit per free output slot.
// ----------------------------------------------------------------------------
module ltw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  ltw_pkg::status_t status,
  output ltw_pkg::cmd_t    cmd
);

  ltw_pkg::state_t state, state_next;
  logic out_valid_next;
  logic slot_free;

  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ltw_pkg::ST_IDLE: if (in_valid) state_next = ltw_pkg::ST_WALK;
      ltw_pkg::ST_WALK: if (slot_free && status.next_is_last) state_next = ltw_pkg::ST_IDLE;
      default:          state_next = ltw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd.load = 1'b0;
    cmd.emit = 1'b0;
    unique case (state)
      ltw_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ltw_pkg::ST_WALK: cmd.emit = slot_free;
      default: ;
    endcase
    out_valid_next = cmd.emit ? 1'b1 : (out_stall ? out_valid : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ltw_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== design/line_tile_walker_4conn_top.sv =====
// ----------------------------------------------------------------------------
// line_tile_walker_4conn_top: 4-connected Bresenham tile line walker
// Turns one start/end tile request into the ordered tiles of its line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one line request.
//   Coordinates above GRID_SIZE-1 are saturated. Output channel
//   (out_valid/out_stall/out_data) carries one tile per transaction, the
//   end tile marked with last_tile. A request yields 1+dx+dy tiles.
//   After acceptance the walk state is entered; its first emit loads the
//   first tile into the output register. Tiles follow at one tile per cycle
//   while the output is not stalled. in_stall is high while a walk is in
//   progress; the next request may be accepted while the last tile still
//   waits in the output register.
//   A stalled output holds its tile and freezes the walk until taken.
//   Reset (rst, synchronous) returns to idle and drops out_valid.
// ----------------------------------------------------------------------------
module line_tile_walker_4conn_top #(
  parameter int GRID_SIZE = ltw_pkg::GRID_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ltw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ltw_pkg::out_item_t out_data
);

  ltw_pkg::cmd_t    cmd;
  ltw_pkg::status_t status;

  ltw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ltw_datapath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_datapath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: regression bench for the 4-connected tile line walker
// Sends line requests through the valid/stall input channel: a short table
// of corner cases, then about 160 random lines of mixed shapes. Every tile
// taken from the output is checked against the table tile or an in-bench
// line predictor, with random gaps on the sender and random receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID      = ltw_pkg::GRID_SIZE_DEF;
  localparam int MAX_TILES = 2 * GRID - 1;
  localparam int N_RANDOM  = 160;
  localparam int LIMIT     = 1000000;
  localparam int N_DIR     = 20;

  typedef struct packed {
    ltw_pkg::in_item_t  req;
    logic               typed;
    ltw_pkg::out_item_t tile;
  } dir_row_t;

  localparam ltw_pkg::out_item_t NO_TILE = '0;

  // typed rows are single-tile lines; the rest go through the predictor
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{'{5'd0,  5'd0,  5'd0,  5'd0},  1'b1, '{5'd0,  5'd0,  1'b1}},
    '{'{5'd31, 5'd31, 5'd31, 5'd31}, 1'b1, '{5'd31, 5'd31, 1'b1}},
    '{'{5'd0,  5'd31, 5'd0,  5'd31}, 1'b1, '{5'd0,  5'd31, 1'b1}},
    '{'{5'd31, 5'd0,  5'd31, 5'd0},  1'b1, '{5'd31, 5'd0,  1'b1}},
    '{'{5'd21, 5'd10, 5'd21, 5'd10}, 1'b1, '{5'd21, 5'd10, 1'b1}},
    '{'{5'd0,  5'd0,  5'd31, 5'd31}, 1'b0, NO_TILE},
    '{'{5'd31, 5'd31, 5'd0,  5'd0},  1'b0, NO_TILE},
    '{'{5'd0,  5'd31, 5'd31, 5'd0},  1'b0, NO_TILE},
    '{'{5'd31, 5'd0,  5'd0,  5'd31}, 1'b0, NO_TILE},
    '{'{5'd0,  5'd0,  5'd31, 5'd0},  1'b0, NO_TILE},
    '{'{5'd31, 5'd5,  5'd0,  5'd5},  1'b0, NO_TILE},
    '{'{5'd7,  5'd0,  5'd7,  5'd31}, 1'b0, NO_TILE},
    '{'{5'd7,  5'd31, 5'd7,  5'd0},  1'b0, NO_TILE},
    '{'{5'd3,  5'd4,  5'd4,  5'd4},  1'b0, NO_TILE},
    '{'{5'd3,  5'd4,  5'd3,  5'd5},  1'b0, NO_TILE},
    '{'{5'd3,  5'd4,  5'd4,  5'd5},  1'b0, NO_TILE},
    '{'{5'd10, 5'd10, 5'd20, 5'd13}, 1'b0, NO_TILE},
    '{'{5'd10, 5'd10, 5'd13, 5'd20}, 1'b0, NO_TILE},
    '{'{5'd20, 5'd20, 5'd5,  5'd14}, 1'b0, NO_TILE},
    '{'{5'd5,  5'd25, 5'd28, 5'd2},  1'b0, NO_TILE}
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  ltw_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  ltw_pkg::out_item_t out_data;

  ltw_pkg::out_item_t tile_q[$];
  ltw_pkg::out_item_t want;
  int        err_cnt   = 0;
  int        cycle_cnt = 0;
  bit        bursty    = 1'b1;

  line_tile_walker_4conn_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_coord(input int v);
    return (v > GRID - 1) ? GRID - 1 : v;
  endfunction

  function automatic ltw_pkg::out_item_t tile_at(input int x, input int y, input bit last);
    ltw_pkg::out_item_t t;
    t.tile_x    = 5'(x);
    t.tile_y    = 5'(y);
    t.last_tile = last;
    return t;
  endfunction

  function automatic void queue_tile(input ltw_pkg::out_item_t t);
    tile_q.insert(tile_q.size(), t);
  endfunction

  // Bresenham walk with the extra corner tile on every diagonal step
  function automatic void walk_line(input ltw_pkg::in_item_t r);
    int  x0, y0, x1, y1, dx, dy, sx, sy, err, e2, cx, cy, n;
    bit  at_end, mx, my;
    x0  = clamp_coord(int'(r.start_x));
    y0  = clamp_coord(int'(r.start_y));
    x1  = clamp_coord(int'(r.end_x));
    y1  = clamp_coord(int'(r.end_y));
    dx  = (x0 > x1) ? x0 - x1 : x1 - x0;
    dy  = (y0 > y1) ? y0 - y1 : y1 - y0;
    sx  = (x0 < x1) ? 1 : -1;
    sy  = (y0 < y1) ? 1 : -1;
    err = dx - dy;
    cx  = x0;
    cy  = y0;
    n   = 0;
    while (1'b1) begin
      at_end = (cx == x1) && (cy == y1);
      if (n >= MAX_TILES) break;
      queue_tile(tile_at(cx, cy, at_end || n == MAX_TILES - 1));
      n++;
      if (at_end) break;
      e2 = 2 * err;
      mx = e2 > -dy;
      my = e2 < dx;
      if (mx) begin
        err -= dy;
        cx  += sx;
      end
      if (my) begin
        err += dx;
        cy  += sy;
        if (mx && n < MAX_TILES) begin
          queue_tile(tile_at(cx, cy - sy, 1'b0));
          n++;
        end
      end
    end
  endfunction

  function automatic logic [4:0] nudge(input logic [4:0] c);
    int t;
    t = int'(c) + int'($urandom_range(0, 6)) - 3;
    return 5'((t < 0) ? 0 : ((t > GRID - 1) ? GRID - 1 : t));
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_line(input ltw_pkg::in_item_t req, input bit typed,
                           input ltw_pkg::out_item_t tile);
    if (bursty && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed) queue_tile(tile);
    else walk_line(req);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (tile_q.size() != 0);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (bursty && !rst && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (tile_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected tile, expected none, got x=%0d y=%0d last=%0d",
                 $time, out_data.tile_x, out_data.tile_y, out_data.last_tile);
      end else begin
        want = tile_q.pop_front();
        if (out_data.tile_x !== want.tile_x || out_data.tile_y !== want.tile_y ||
            out_data.last_tile !== want.last_tile) begin
          err_cnt++;
          $display("%0t: tile mismatch, expected x=%0d y=%0d last=%0d, got x=%0d y=%0d last=%0d",
                   $time, want.tile_x, want.tile_y, want.last_tile,
                   out_data.tile_x, out_data.tile_y, out_data.last_tile);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("line_tile_walker_4conn_top regression: fail");
      $finish;
    end
  end

  initial begin
    ltw_pkg::in_item_t r;
    int       d, x0, y0;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_line(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].tile);
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      bursty = (i < 130) && ((i / 25) % 3 != 2);
      if (i == 90) drain();
      r.start_x = 5'($urandom_range(0, 31));
      r.start_y = 5'($urandom_range(0, 31));
      r.end_x   = 5'($urandom_range(0, 31));
      r.end_y   = 5'($urandom_range(0, 31));
      case ($urandom_range(0, 9))
        0: begin
          r.end_x = r.start_x;
          r.end_y = r.start_y;
        end
        1: r.end_y = r.start_y;
        2: r.end_x = r.start_x;
        3: begin
          d  = $urandom_range(0, 31);
          x0 = $urandom_range(0, 31 - d);
          y0 = $urandom_range(0, 31 - d);
          if ($urandom_range(0, 1) == 0) begin
            r.start_x = 5'(x0);
            r.end_x   = 5'(x0 + d);
          end else begin
            r.start_x = 5'(x0 + d);
            r.end_x   = 5'(x0);
          end
          if ($urandom_range(0, 1) == 0) begin
            r.start_y = 5'(y0);
            r.end_y   = 5'(y0 + d);
          end else begin
            r.start_y = 5'(y0 + d);
            r.end_y   = 5'(y0);
          end
        end
        4, 5: begin
          r.end_x = nudge(r.start_x);
          r.end_y = nudge(r.start_y);
        end
        default: ;
      endcase
      send_line(r, 1'b0, NO_TILE);
    end

    drain();
    repeat (10) @(negedge clk);
    if (err_cnt == 0)
      $display("line_tile_walker_4conn_top regression: pass");
    else
      $display("line_tile_walker_4conn_top regression: fail");
    $finish;
  end

endmodule

// ===== line_tile_walker_4conn_top.f =====
design/ltw_pkg.sv
design/ltw_datapath.sv
design/ltw_ctrl.sv
design/line_tile_walker_4conn_top.sv
verif/tb.sv
